/* hdl/dns_query_validator_macros.svh */
// Assertion macros shared by the DNS query validator
`ifndef DNS_QUERY_VALIDATOR_MACROS_SVH
`define DNS_QUERY_VALIDATOR_MACROS_SVH

// Same-cycle implication, reset masked
`define DQV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked
`define DQV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dqv_pkg.sv */
// Types and constants of the DNS query validator
`timescale 1ns / 1ps
package dqv_pkg;

  localparam int CfgW   = 14;
  localparam int HdrLen = 12;
  localparam int QtcLen = 5;   // terminator or pointer low byte plus QTYPE/QCLASS

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DROP   = 2'd1;
  localparam logic [1:0] VERDICT_ERROR  = 2'd2;

  localparam logic [1:0] REG_MAX_LEN    = 2'd0;
  localparam logic [1:0] REG_DROP_MULTI = 2'd1;
  localparam logic [1:0] REG_DROP_LARGE = 2'd2;
  localparam logic [1:0] REG_DROP_LONG  = 2'd3;

  localparam logic [7:0] PTR_MARK    = 8'hC0;
  localparam logic [7:0] LABEL_LIMIT = 8'd63;

  typedef struct packed {
    logic       wr;         // store accepted byte
    logic       eval_clr;   // start of evaluation
    logic       set_verdict;
    logic [1:0] verdict;
    logic       walk_init;
    logic       name_init;
    logic       rd;         // read byte at walk position
    logic       rd_next;    // read byte after walk position
    logic       step_data;  // consume length or name byte, or capture pointer high byte
    logic       step_ptr;   // follow compression pointer
    logic       name_done;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic short_msg;
    logic hdr_drop;
    logic qc_zero;
    logic pos_fault;
    logic is_len_pos;
    logic c_zero;
    logic c_ptr;
    logic ptr_oob;
    logic name_drop;
    logic last_q;
    logic out_free;
  } sts_t;

endpackage

/* hdl/dqv_ctrl.sv */
// Sequencing state machine of the DNS query validator
`timescale 1ns / 1ps
module dqv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_byte_i,
  output logic          in_ready_o,
  input  dqv_pkg::sts_t sts_i,
  output dqv_pkg::cmd_t cmd_o
);
  import dqv_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_NINIT = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_DATA  = 4'd4;
  localparam logic [3:0] S_PTR   = 4'd5;
  localparam logic [3:0] S_NEND  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr = 1'b1;
          if (last_byte_i) state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval_clr = 1'b1;
        if (sts_i.short_msg) begin
          cmd_o.set_verdict = 1'b1;
          cmd_o.verdict     = VERDICT_ERROR;
          state_d           = S_DONE;
        end else if (sts_i.hdr_drop) begin
          cmd_o.set_verdict = 1'b1;
          cmd_o.verdict     = VERDICT_DROP;
          state_d           = S_DONE;
        end else if (sts_i.qc_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_NINIT;
        end
      end
      S_NINIT: begin
        cmd_o.name_init = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.pos_fault) begin
          cmd_o.set_verdict = 1'b1;
          cmd_o.verdict     = VERDICT_ERROR;
          state_d           = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_DATA;
        end
      end
      S_DATA: begin
        if (sts_i.is_len_pos && sts_i.c_zero) begin
          state_d = S_NEND;
        end else if (sts_i.is_len_pos && sts_i.c_ptr) begin
          if (sts_i.ptr_oob) begin
            cmd_o.set_verdict = 1'b1;
            cmd_o.verdict     = VERDICT_ERROR;
            state_d           = S_DONE;
          end else begin
            cmd_o.rd_next   = 1'b1;
            cmd_o.step_data = 1'b1;
            state_d         = S_PTR;
          end
        end else begin
          cmd_o.step_data = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_PTR: begin
        cmd_o.step_ptr = 1'b1;
        state_d        = S_CHECK;
      end
      S_NEND: begin
        cmd_o.name_done = 1'b1;
        if (sts_i.name_drop) begin
          cmd_o.set_verdict = 1'b1;
          cmd_o.verdict     = VERDICT_DROP;
          state_d           = S_DONE;
        end else if (sts_i.last_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_NINIT;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

/* hdl/dqv_datapath.sv */
// Message buffer, walk counters and result registers of the DNS query validator
`timescale 1ns / 1ps
module dqv_datapath #(
  parameter int MAX_MESSAGE_BYTES = 8192,
  parameter int NAME_LIMIT        = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7:0]                msg_byte_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [dqv_pkg::CfgW-1:0]  cfg_wdata_i,
  input  dqv_pkg::cmd_t             cmd_i,
  output dqv_pkg::sts_t             sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                verdict_o,
  output logic [15:0]               query_id_o,
  output logic [15:0]               question_count_o,
  output logic [8:0]                name_length_o
);
  import dqv_pkg::*;

  localparam int ADDR_W = $clog2(MAX_MESSAGE_BYTES);
  localparam int CNT_W  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int POS_W  = (CNT_W + 1 > 14) ? CNT_W + 1 : 14;
  localparam int STEP_W = CNT_W + 1;
  localparam int NL_W   = $clog2(NAME_LIMIT + 6);
  localparam logic [NL_W-1:0] NL_SAT = NL_W'(NAME_LIMIT + 1);
  localparam logic [NL_W-1:0] NL_LIM = NL_W'(NAME_LIMIT);

  logic [7:0] mem_q [MAX_MESSAGE_BYTES];
  logic [7:0] rdata_q, c_q;

  // config
  logic [CfgW-1:0] max_len_q;
  logic            drop_multi_q, drop_large_q, drop_long_q;

  // load side
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic [15:0]      qid_q, qc_q;
  logic [7:0]       flags_q;

  // walk side
  logic [POS_W-1:0]  wpos_q, nlp_q, end_q;
  logic              have_end_q, longl_q;
  logic [STEP_W-1:0] step_q;
  logic [NL_W-1:0]   nlen_q, nl_q;
  logic [16:0]       qi_q;
  logic [1:0]        verdict_q;

  logic [POS_W-1:0]  len_w, pos_p1, base;
  logic [ADDR_W-1:0] rd_addr;
  logic [NL_W-1:0]   inc, nsum, esc;
  logic              is_char;

  assign len_w   = POS_W'(cnt_q);
  assign pos_p1  = wpos_q + POS_W'(1);
  assign rd_addr = cmd_i.rd_next ? pos_p1[ADDR_W-1:0] : wpos_q[ADDR_W-1:0];
  assign is_char = (rdata_q >= 8'h21) && (rdata_q <= 8'h7A) && (rdata_q != 8'h5C);
  assign inc     = (sts_o.is_len_pos || is_char) ? NL_W'(1) : NL_W'(4);
  assign nsum    = nlen_q + inc;
  assign esc     = nlen_q + NL_W'(1);
  assign base    = have_end_q ? end_q : wpos_q;

  always_comb begin
    sts_o            = '0;
    sts_o.short_msg  = cnt_q < CNT_W'(HdrLen);
    sts_o.hdr_drop   = ovf_q || ({1'b0, cnt_q} > (CNT_W + 1)'(max_len_q))
                       || (flags_q[7:3] != 5'd0) || (qc_q > 16'd1 && drop_multi_q);
    sts_o.qc_zero    = qc_q == 16'd0;
    sts_o.pos_fault  = (wpos_q >= len_w) || (step_q >= {cnt_q, 1'b0});
    sts_o.is_len_pos = nlp_q == wpos_q;
    sts_o.c_zero     = rdata_q == 8'd0;
    sts_o.c_ptr      = (rdata_q & PTR_MARK) == PTR_MARK;
    sts_o.ptr_oob    = pos_p1 >= len_w;
    sts_o.name_drop  = (esc > NL_LIM && drop_large_q) || (longl_q && drop_long_q);
    sts_o.last_q     = (qi_q + 17'd1) == {1'b0, qc_q};
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

  // buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && cnt_q < CNT_W'(MAX_MESSAGE_BYTES)) begin
      mem_q[cnt_q[ADDR_W-1:0]] <= msg_byte_i;
    end
    if (cmd_i.rd || cmd_i.rd_next) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // header capture and walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      case (cnt_q)
        CNT_W'(0): qid_q[15:8] <= msg_byte_i;
        CNT_W'(1): qid_q[7:0]  <= msg_byte_i;
        CNT_W'(2): flags_q     <= msg_byte_i;
        CNT_W'(4): qc_q[15:8]  <= msg_byte_i;
        CNT_W'(5): qc_q[7:0]   <= msg_byte_i;
        default: ;
      endcase
    end
    if (cmd_i.walk_init) begin
      wpos_q <= POS_W'(HdrLen);
      qi_q   <= '0;
    end
    if (cmd_i.name_init) begin
      nlp_q      <= wpos_q;
      step_q     <= '0;
      have_end_q <= 1'b0;
      nlen_q     <= '0;
      longl_q    <= 1'b0;
    end
    if (cmd_i.step_data) begin
      if (sts_o.is_len_pos && sts_o.c_ptr) begin
        c_q <= rdata_q;
      end else begin
        step_q <= step_q + STEP_W'(1);
        nlen_q <= (nsum > NL_SAT) ? NL_SAT : nsum;
        wpos_q <= pos_p1;
        if (sts_o.is_len_pos) begin
          nlp_q <= wpos_q + POS_W'(rdata_q) + POS_W'(1);
          if (rdata_q > LABEL_LIMIT) longl_q <= 1'b1;
        end
      end
    end
    if (cmd_i.step_ptr) begin
      step_q <= step_q + STEP_W'(1);
      if (!have_end_q) begin
        end_q      <= pos_p1;
        have_end_q <= 1'b1;
      end
      wpos_q <= POS_W'({c_q[5:0], rdata_q});
      nlp_q  <= POS_W'({c_q[5:0], rdata_q});
    end
    if (cmd_i.name_done) begin
      nl_q   <= (esc > NL_LIM) ? NL_SAT : esc;
      wpos_q <= base + POS_W'(QtcLen);
      qi_q   <= qi_q + 17'd1;
    end
    if (cmd_i.eval_clr) begin
      nl_q <= '0;
    end
    if (cmd_i.emit) begin
      verdict_o        <= verdict_q;
      query_id_o       <= sts_o.short_msg ? 16'd0 : qid_q;
      question_count_o <= sts_o.short_msg ? 16'd0 : qc_q;
      name_length_o    <= 9'(nl_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= CfgW'(8192);
      drop_multi_q <= 1'b0;
      drop_large_q <= 1'b0;
      drop_long_q  <= 1'b0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      verdict_q    <= VERDICT_ACCEPT;
      out_valid_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_LEN:    max_len_q    <= cfg_wdata_i;
          REG_DROP_MULTI: drop_multi_q <= cfg_wdata_i[0];
          REG_DROP_LARGE: drop_large_q <= cfg_wdata_i[0];
          REG_DROP_LONG:  drop_long_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.wr) begin
        if (cnt_q < CNT_W'(MAX_MESSAGE_BYTES)) cnt_q <= cnt_q + CNT_W'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.set_verdict) verdict_q <= cmd_i.verdict;
      else if (cmd_i.eval_clr) verdict_q <= VERDICT_ACCEPT;
      if (cmd_i.emit) begin
        cnt_q       <= '0;
        ovf_q       <= 1'b0;
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

/* hdl/dns_query_validator.sv */
// Top level of the DNS query validator
// A DNS message enters one byte per transaction (one per cycle while in_ready_o is high)
// and is stored in an on-chip buffer of MAX_MESSAGE_BYTES entries; the transaction marked
// last_byte closes the message. The block then checks the header (12-byte minimum,
// length limit from max_message_length, QR/opcode zero, optional multi-question drop) and
// walks every question name, following compression pointers under a step guard of twice
// the message length. Each walk step reads the buffer through its single read port, and a
// pointer step also passes the pointer state; each question adds name setup, terminator
// read and name close, and each message a header check and a result hand-off. One result
// transaction (verdict, query id, question count, last name length) follows per message;
// the next message loads while it waits to be taken. Configuration writes take effect at
// once and belong in idle periods.
`timescale 1ns / 1ps
module dns_query_validator #(
  parameter int MAX_MESSAGE_BYTES = 8192,
  parameter int NAME_LIMIT        = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               msg_byte_i,
  input  logic                     last_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               verdict_o,
  output logic [15:0]              query_id_o,
  output logic [15:0]              question_count_o,
  output logic [8:0]               name_length_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [dqv_pkg::CfgW-1:0] cfg_wdata_i
);
  import dqv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: load, header checks, per-name walk, result hand-off
  dqv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // buffer, counters, config and output register
  dqv_datapath #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .NAME_LIMIT        (NAME_LIMIT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .msg_byte_i       (msg_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_o        (verdict_o),
    .query_id_o       (query_id_o),
    .question_count_o (question_count_o),
    .name_length_o    (name_length_o)
  );

`include "dns_query_validator_macros.svh"

  // closing byte stops intake until the verdict is produced
  `DQV_ASSERT_NEXT(a_last_stops_intake, in_valid_i && in_ready_o && last_byte_i, !in_ready_o, "intake open after last byte")
  // a new result is loaded only while intake is closed
  `DQV_ASSERT_NOW(a_result_while_busy, cmd.emit, !in_ready_o, "result loaded during intake")
  // the reserved verdict code never appears
  `DQV_ASSERT_NOW(a_verdict_code, out_valid_o, verdict_o == VERDICT_ACCEPT || verdict_o == VERDICT_DROP || verdict_o == VERDICT_ERROR, "bad verdict code")

endmodule
